// ----- sv/lsm_pkg.sv -----
package lsm_pkg;

  // Pattern register file: two 64-bit words hold up to 16 bytes
  localparam int unsigned REG_BYTES   = 16;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned LINE_W      = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned MAX_PATTERN_DEFAULT = 16;

  localparam logic [7:0] NEWLINE   = 8'd10;
  localparam logic [7:0] UPPER_A   = 8'd65;
  localparam logic [7:0] UPPER_Z   = 8'd90;
  localparam logic [7:0] CASE_OFFS = 8'd32;

  typedef logic [7:0]        byte_t;
  typedef logic [LINE_W-1:0] line_num_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 8'd0,
    CFG_PATTERN_HIGH   = 8'd1,
    CFG_PATTERN_LENGTH = 8'd2,
    CFG_IGNORE_CASE    = 8'd3
  } cfg_index_t;

  // Control shared by every cell of the window row
  typedef struct packed {
    logic shift;
    logic clear;
    logic ignore_case;
  } cell_ctrl_t;

  function automatic byte_t fold(input byte_t c, input logic ic);
    if (ic && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_OFFS;
    end
    return c;
  endfunction

endpackage

// ----- sv/lsm_if.sv -----
interface lsm_text_if;
  import lsm_pkg::*;
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lsm_result_if;
  import lsm_pkg::*;
  logic      valid;
  logic      ready;
  line_num_t line_id;
  logic      line_matched;
  logic      final_line;
  logic      any_matched;
  modport source (output valid, output line_id, output line_matched,
                  output final_line, output any_matched, input ready);
  modport sink   (input valid, input line_id, input line_matched,
                  input final_line, input any_matched, output ready);
endinterface

interface lsm_cfg_if;
  import lsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/lsm_cell.sv -----
module lsm_cell (
  input  logic               clk,
  input  logic               rst,
  input  lsm_pkg::cell_ctrl_t ctrl,
  input  lsm_pkg::byte_t     byte_in,
  input  logic               valid_in,
  input  lsm_pkg::byte_t     pat_byte,
  input  logic               in_use,
  output lsm_pkg::byte_t     byte_out,
  output logic               valid_out,
  output logic               ok
);
  import lsm_pkg::*;

  byte_t data;
  logic  valid;

  // compare against the byte entering this position on this shift
  assign ok = !in_use ||
              (valid_in && (fold(byte_in, ctrl.ignore_case) ==
                            fold(pat_byte, ctrl.ignore_case)));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= ctrl.clear ? 1'b0 : valid_in;
    end
  end

  assign byte_out  = data;
  assign valid_out = valid;

endmodule

// ----- sv/line_substring_matcher_core.sv -----
// Per-line substring search. One text byte is taken per clock, every clock,
// as long as the result register is free or being drained in the same cycle;
// the row of window cells shifts the new byte in and compares the whole
// window against the pattern in that same cycle. A result item leaves for
// every newline byte (the newline is part of its line) and for the byte
// flagged end_of_text; it is held in a single output register, so text
// stalls while a result waits unaccepted. Pattern, length and case folding
// are written over the configuration channel (index 0 low pattern word,
// 1 high word, 2 length, 3 ignore_case); it is always ready. Lengths beyond
// the cell count are clipped; zero matches every line. No start-up pass is
// needed after reset.
module line_substring_matcher_core #(
  parameter int unsigned MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  lsm_text_if.sink     text,
  lsm_result_if.source result,
  lsm_cfg_if.sink      cfg
);
  import lsm_pkg::*;

  // cells actually compared: the pattern registers hold at most REG_BYTES
  localparam int unsigned CELLS = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

  // ---------------- configuration registers ----------------
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]      pattern_length;
  logic                  ignore_case;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      ignore_case    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PATTERN_LOW:    pattern_low    <= cfg.data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg.data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg.data[LEN_W-1:0];
        CFG_IGNORE_CASE:    ignore_case    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // effective length, clipped to the cell count
  logic [LEN_W-1:0] eff_len;
  assign eff_len = (pattern_length > LEN_W'(CELLS)) ? LEN_W'(CELLS) : pattern_length;

  // pattern as bytes, byte 0 first
  byte_t pat [REG_BYTES];
  always_comb begin
    for (int k = 0; k < REG_BYTES / 2; k++) begin
      pat[k]                 = pattern_low[8*k +: 8];
      pat[k + REG_BYTES / 2] = pattern_high[8*k +: 8];
    end
  end

  // ---------------- handshake and line control ----------------
  logic in_acc;
  logic line_end;
  logic out_valid;

  assign text.ready = !out_valid || result.ready;
  assign in_acc     = text.valid && text.ready;
  assign line_end   = (text.text_byte == NEWLINE) || text.end_of_text;

  cell_ctrl_t ctrl;
  assign ctrl.shift       = in_acc;
  assign ctrl.clear       = line_end;
  assign ctrl.ignore_case = ignore_case;

  // ---------------- window cell row ----------------
  // cell 0 holds the newest byte; valid bits mark how much of the line is in
  byte_t      cell_byte  [CELLS];
  logic       cell_valid [CELLS];
  logic [CELLS-1:0] cell_ok;

  genvar i;
  generate
    for (i = 0; i < CELLS; i++) begin : g_cell
      byte_t            byte_in;
      logic             valid_in;
      logic [LEN_W-2:0] pat_pos;
      logic             in_use;

      if (i == 0) begin : g_head
        assign byte_in  = text.text_byte;
        assign valid_in = 1'b1;
      end else begin : g_body
        assign byte_in  = cell_byte[i-1];
        assign valid_in = cell_valid[i-1];
      end

      // window position i lines up with pattern byte eff_len-1-i
      assign in_use  = LEN_W'(i) < eff_len;
      assign pat_pos = (LEN_W-1)'(eff_len - LEN_W'(1) - LEN_W'(i));

      lsm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .byte_in  (byte_in),
        .valid_in (valid_in),
        .pat_byte (pat[pat_pos]),
        .in_use   (in_use),
        .byte_out (cell_byte[i]),
        .valid_out(cell_valid[i]),
        .ok       (cell_ok[i])
      );
    end
  endgenerate

  // ---------------- per-line and per-text state ----------------
  logic      hit_in_line;
  logic      hit_anywhere;
  line_num_t current_line;
  logic      line_hit;
  logic      any_hit;

  assign line_hit = hit_in_line || (&cell_ok);
  assign any_hit  = hit_anywhere || line_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_in_line  <= 1'b0;
      hit_anywhere <= 1'b0;
      current_line <= line_num_t'(1);
    end else if (in_acc) begin
      if (text.end_of_text) begin
        hit_in_line  <= 1'b0;
        hit_anywhere <= 1'b0;
        current_line <= line_num_t'(1);
      end else if (line_end) begin
        hit_in_line  <= 1'b0;
        hit_anywhere <= any_hit;
        if (current_line != '1) begin
          current_line <= current_line + line_num_t'(1);
        end
      end else begin
        hit_in_line <= line_hit;
      end
    end
  end

  // ---------------- result register ----------------
  line_num_t out_line;
  logic      out_matched;
  logic      out_final;
  logic      out_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && line_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && line_end) begin
      out_line    <= current_line;
      out_matched <= line_hit;
      out_final   <= text.end_of_text;
      out_any     <= any_hit;
    end
  end

  assign result.valid        = out_valid;
  assign result.line_id      = out_line;
  assign result.line_matched = out_matched;
  assign result.final_line   = out_final;
  assign result.any_matched  = out_any;

endmodule

// ----- verif/tb.sv -----
module tb;
  import lsm_pkg::*;

  // Stimulus sizing and time limits
  localparam int unsigned TEXT_ITEMS    = 1550;
  localparam int unsigned IDLE_LIMIT    = 2000;  // cycles with no handshake at all
  localparam int unsigned SETTLE_CYCLES = 4;     // compare is same-cycle, result is one reg
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned WIN_DEPTH     = 16;    // matches MAX_PATTERN default
  localparam int unsigned MAX_PRINTS    = 40;

  // One finished line as seen on the result channel
  typedef struct packed {
    line_num_t line_id;
    logic      line_matched;
    logic      final_line;
    logic      any_matched;
  } line_result_t;

  typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_t;

  // One row of the directed table: a text item or a register write.
  // 'typed' rows carry a hand-written expectation instead of the predicted one.
  typedef struct packed {
    row_kind_t             kind;
    byte_t                 text_byte;
    logic                  end_of_text;
    cfg_index_t            index;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    line_result_t          known;
  } stim_row_t;

  logic clk;
  logic rst;

  lsm_text_if   text();
  lsm_result_if result();
  lsm_cfg_if    cfg();

  line_substring_matcher_core u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .result (result),
    .cfg    (cfg)
  );

  // ---------------------------------------------------------------------------
  // Line matcher prediction: shadow registers and per-line search state
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] pat_lo   = '0;
  logic [CFG_DATA_W-1:0] pat_hi   = '0;
  logic [LEN_W-1:0]      pat_len  = '0;
  logic                  fold_on  = 1'b0;

  byte_t       tail_bytes [WIN_DEPTH] = '{default: '0};  // [0] is the newest byte
  int unsigned line_fill  = 0;                           // saturates at WIN_DEPTH
  logic        line_hit   = 1'b0;
  logic        text_hit   = 1'b0;
  line_num_t   line_count = 1;

  line_result_t pending_lines [$];
  stim_row_t    dir_rows [$];
  int unsigned  errors      = 0;
  int unsigned  idle_cycles = 0;

  // Result side stall pattern
  int unsigned ready_left = 0;
  bit          ready_mode = 1'b0;

  function automatic byte_t pat_at(input int unsigned k);
    logic [2*CFG_DATA_W-1:0] both;
    both = {pat_hi, pat_lo};
    return both[8*k +: 8];
  endfunction

  // Length in force, clipped to the window depth
  function automatic int unsigned used_len();
    return (pat_len > WIN_DEPTH) ? WIN_DEPTH : int'(pat_len);
  endfunction

  function automatic byte_t lower(input byte_t c);
    return (fold_on && c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  // Shift one byte into the line window, update the hit flags, and return 1
  // with the finished line when the byte closes a line or the text.
  function automatic logic predict_line_end(input byte_t b, input logic eot,
                                            output line_result_t res);
    int unsigned n;
    int unsigned i;
    logic        same;
    n = used_len();
    for (i = WIN_DEPTH - 1; i > 0; i--) tail_bytes[i] = tail_bytes[i-1];
    tail_bytes[0] = b;
    if (line_fill < WIN_DEPTH) line_fill++;

    // empty pattern hits every line; otherwise compare once enough bytes are in
    if (n == 0) begin
      line_hit = 1'b1;
    end else if (line_fill >= n) begin
      same = 1'b1;
      for (i = 0; i < n; i++) begin
        if (lower(tail_bytes[n-1-i]) != lower(pat_at(i))) same = 1'b0;
      end
      if (same) line_hit = 1'b1;
    end

    res = '0;
    if (b != NEWLINE && !eot) return 1'b0;

    text_hit = text_hit | line_hit;
    res.line_id      = line_count;
    res.line_matched = line_hit;
    res.final_line   = eot;
    res.any_matched  = text_hit;

    // new line: window and hit flag restart; end of text also restarts the count
    foreach (tail_bytes[m]) tail_bytes[m] = '0;
    line_fill = 0;
    line_hit  = 1'b0;
    if (eot) begin
      line_count = 1;
      text_hit   = 1'b0;
    end else if (line_count != '1) begin
      line_count++;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(input bit busy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (busy || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bytes for patterns and filler text: a few letters both cases, the
  // byte extremes, newline, and plain noise.
  function automatic byte_t pool_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return NEWLINE;
    if (r == 2) return 8'hFF;
    if (r <= 5) return 8'h61 + byte_t'($urandom_range(0, 2));
    if (r <= 7) return 8'h41 + byte_t'($urandom_range(0, 2));
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Flip the case of a letter now and then; often when folding is on
  function automatic byte_t twist_case(input byte_t b);
    byte_t lc;
    lc = b | 8'h20;
    if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(0, 9) < (fold_on ? 5 : 1))
      return b ^ 8'h20;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic void add_text(input byte_t b, input logic eot);
    stim_row_t row;
    row             = '0;
    row.kind        = ROW_TEXT;
    row.text_byte   = b;
    row.end_of_text = eot;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known(input byte_t b, input logic eot, input line_num_t num,
                                    input logic hit, input logic fin, input logic any);
    stim_row_t row;
    row                    = '0;
    row.kind               = ROW_TEXT;
    row.text_byte          = b;
    row.end_of_text        = eot;
    row.typed              = 1'b1;
    row.known.line_id      = num;
    row.known.line_matched = hit;
    row.known.final_line   = fin;
    row.known.any_matched  = any;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.index = idx;
    row.data  = value;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one text item, wait for the handshake, then predict. An optional
  // gap drops valid afterwards; with no gap valid stays high for the next item.
  task automatic push_text(input byte_t b, input logic eot, input logic typed,
                           input line_result_t known, input int unsigned gap);
    line_result_t res;
    cfg.valid        <= 1'b0;  // closes any register burst just before
    text.valid       <= 1'b1;
    text.text_byte   <= b;
    text.end_of_text <= eot;
    do @(posedge clk); while (!text.ready);
    if (predict_line_end(b, eot, res)) pending_lines.push_back(typed ? known : res);
    if (gap > 0) begin
      text.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write; caller has made the block idle first
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_PATTERN_LOW:    pat_lo  = value;
      CFG_PATTERN_HIGH:   pat_hi  = value;
      CFG_PATTERN_LENGTH: pat_len = value[LEN_W-1:0];
      CFG_IGNORE_CASE:    fold_on = value[0];
      default: ;
    endcase
  endtask

  // Stop offering, let every expected line drain, then give the window a
  // few cycles since a byte that closes no line leaves nothing to wait on.
  task automatic settle();
    text.valid <= 1'b0;
    cfg.valid  <= 1'b0;
    wait (pending_lines.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Result side: random ready, mostly short stalls, a few long ones, and
  // long stretches of steady ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 19))
        0:             begin ready_mode = 1'b0; ready_left = $urandom_range(10, 40);   end
        1, 2:          begin ready_mode = 1'b1; ready_left = $urandom_range(100, 300); end
        3, 4, 5, 6, 7: begin ready_mode = 1'b0; ready_left = $urandom_range(1, 3);     end
        default:       begin ready_mode = 1'b1; ready_left = $urandom_range(1, 20);    end
      endcase
    end
    ready_left--;
    result.ready <= ready_mode;
  end

  // Result checker: each accepted line against the oldest expectation
  always @(posedge clk) begin
    line_result_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_lines.size() == 0) begin
        report_mismatch("line result with none expected, line_id",
                        result.line_id, 0);
      end else begin
        want = pending_lines.pop_front();
        if (result.line_id !== want.line_id)
          report_mismatch("line_id", result.line_id, want.line_id);
        if (result.line_matched !== want.line_matched)
          report_mismatch("line_matched", result.line_matched, want.line_matched);
        if (result.final_line !== want.final_line)
          report_mismatch("final_line", result.final_line, want.final_line);
        if (result.any_matched !== want.any_matched)
          report_mismatch("any_matched", result.any_matched, want.any_matched);
      end
    end
  end

  // Watchdog: no handshake on any channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (text.valid && text.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned           sent;
    int unsigned           phase_len;
    int unsigned           k;
    int unsigned           j;
    int unsigned           n;
    int unsigned           cut;
    int unsigned           pick;
    bit                    busy;
    logic [LEN_W-1:0]      new_len;
    logic [2*CFG_DATA_W-1:0] both;
    logic [CFG_DATA_W-1:0] reg_data;

    rst              <= 1'b1;
    text.valid       <= 1'b0;
    text.text_byte   <= '0;
    text.end_of_text <= 1'b0;
    cfg.valid        <= 1'b0;
    cfg.index        <= CFG_PATTERN_LOW;
    cfg.data         <= '0;

    // -- directed table --
    // after reset the pattern is empty, so every line matches
    add_known(NEWLINE, 1'b0, 1, 1'b1, 1'b0, 1'b1);
    add_known(8'hFF,   1'b1, 2, 1'b1, 1'b1, 1'b1);
    // "AbC" with case folding, junk in the unused pattern bytes
    add_cfg(CFG_PATTERN_LOW, 64'hA5A5_A5A5_A543_6241);
    add_cfg(CFG_PATTERN_LENGTH, 64'd3);
    add_cfg(CFG_IGNORE_CASE, 64'd1);
    add_text(8'h78, 1'b0);  // x a B c \n : match after folding
    add_text(8'h61, 1'b0);
    add_text(8'h42, 1'b0);
    add_text(8'h63, 1'b0);
    add_text(NEWLINE, 1'b0);
    add_text(8'h61, 1'b0);  // a b \n : newline is in the window, no match
    add_text(8'h62, 1'b0);
    add_text(NEWLINE, 1'b0);
    // folding switched off in mid line: a b C no longer matches
    add_text(8'h61, 1'b0);
    add_text(8'h62, 1'b0);
    add_cfg(CFG_IGNORE_CASE, 64'd0);
    add_text(8'h43, 1'b1);
    // zero bytes are ordinary characters on both sides
    add_cfg(CFG_PATTERN_LOW, 64'd0);
    add_cfg(CFG_PATTERN_LENGTH, 64'd2);
    add_text(8'h00, 1'b0);
    add_known(8'h00, 1'b1, 1, 1'b1, 1'b1, 1'b1);
    // over-long length clips to the window; a one-byte line cannot hold it
    add_cfg(CFG_PATTERN_HIGH, '1);
    add_cfg(CFG_PATTERN_LOW, '1);
    add_cfg(CFG_PATTERN_LENGTH, 64'd31);
    add_known(NEWLINE, 1'b0, 1, 1'b0, 1'b0, 1'b0);
    // newline as the pattern matches its own line end
    add_cfg(CFG_PATTERN_LOW, 64'h0A);
    add_cfg(CFG_PATTERN_LENGTH, 64'd1);
    add_known(NEWLINE, 1'b1, 2, 1'b1, 1'b1, 1'b1);
    add_cfg(CFG_PATTERN_LENGTH, 64'd0);
    add_known(8'h80, 1'b1, 1, 1'b1, 1'b1, 1'b1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[r].index, dir_rows[r].data);
      end else begin
        push_text(dir_rows[r].text_byte, dir_rows[r].end_of_text, dir_rows[r].typed,
                  dir_rows[r].known, pick_gap(1'b0));
      end
    end

    // -- random phases: new settings, then text shaped around the pattern --
    sent = 0;
    while (sent < TEXT_ITEMS) begin
      settle();

      // length: mostly short, with empty, full and over-long ones mixed in
      pick = $urandom_range(0, 99);
      if (pick < 8)       new_len = LEN_W'(0);
      else if (pick < 22) new_len = LEN_W'(16);
      else if (pick < 30) new_len = LEN_W'($urandom_range(17, 31));
      else if (pick < 38) new_len = LEN_W'(1);
      else                new_len = LEN_W'($urandom_range(2, 5));

      for (j = 0; j < 2 * CFG_DATA_W / 8; j++) both[8*j +: 8] = pool_byte();
      pick = $urandom_range(0, 9);
      if (pick == 0)      both = '1;
      else if (pick == 1) both = '0;

      write_reg(CFG_PATTERN_LOW, both[CFG_DATA_W-1:0]);
      write_reg(CFG_PATTERN_HIGH, both[2*CFG_DATA_W-1:CFG_DATA_W]);
      // upper bits of the narrow registers are sometimes junk
      reg_data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      write_reg(CFG_PATTERN_LENGTH, {reg_data[CFG_DATA_W-1:LEN_W], new_len});
      reg_data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      write_reg(CFG_IGNORE_CASE, {reg_data[CFG_DATA_W-1:1], 1'($urandom_range(0, 1))});

      busy      = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 120);
      n         = used_len();
      k         = 0;
      while (k < phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 25 && n > 0) begin
          // pattern copy, sometimes cut short
          cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n;
          for (j = 0; j < cut; j++) begin
            push_text(twist_case(pat_at(j)), 1'b0, 1'b0, '0, pick_gap(busy));
            k++;
          end
        end else if (pick < 42) begin
          push_text(NEWLINE, 1'b0, 1'b0, '0, pick_gap(busy));
          k++;
        end else if (pick < 45) begin
          push_text(pool_byte(), 1'b1, 1'b0, '0, pick_gap(busy));
          k++;
        end else if (pick < 55) begin
          push_text(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0),
                    1'b0, '0, pick_gap(busy));
          k++;
        end else begin
          // filler drawn from the pattern so partial matches come up often
          if (n > 0 && $urandom_range(0, 1) == 1)
            push_text(twist_case(pat_at($urandom_range(0, n - 1))), 1'b0, 1'b0, '0,
                      pick_gap(busy));
          else
            push_text(pool_byte(), 1'b0, 1'b0, '0, pick_gap(busy));
          k++;
        end
      end
      sent += k;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_lines.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lsm_pkg.sv
sv/lsm_if.sv
sv/lsm_cell.sv
sv/line_substring_matcher_core.sv
verif/tb.sv
